// ===== design/recency_ordered_cache_table_defines.svh =====
// Assertion macros used by the back stage of the recency ordered cache table.
`ifndef RECENCY_ORDERED_CACHE_TABLE_DEFINES_SVH
`define RECENCY_ORDERED_CACHE_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define RCOT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcot assertion failed");
`define RCOT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcot assertion failed");
`else
`define RCOT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define RCOT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/rcot_pkg.sv =====
// Shared types and constants of the recency ordered cache table.
`timescale 1ns / 1ps
package rcot_pkg;

  localparam int MaxEntries = 16;
  localparam int KeyW       = 32;
  localparam int DataW      = 32;
  localparam int CfgW       = 5;
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam int IdxW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [CfgW-1:0] CapReset = CfgW'(16);

  typedef enum logic [0:0] {
    OP_PUT = 1'b0,
    OP_GET = 1'b1
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [KeyW-1:0]  key;
    logic [DataW-1:0] data;
  } req_t;

endpackage

// ===== design/rcot_front.sv =====
// Front stage: capacity register, input register and operation decode.
`timescale 1ns / 1ps
module rcot_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [rcot_pkg::KeyW-1:0]     in_key_tag,
  input  logic [rcot_pkg::DataW-1:0]    in_data_word,
  input  logic                          cfg_we,
  input  logic [rcot_pkg::CfgW-1:0]     cfg_wdata,
  output logic                          push_valid,
  input  logic                          push_ready,
  output rcot_pkg::req_t                push_data,
  output logic [rcot_pkg::CntW-1:0]     eff_cap
);

  logic                       stg_vld_r;
  logic                       stg_vld_nxt;
  rcot_pkg::req_t             stg_r;
  rcot_pkg::req_t             stg_nxt;
  logic [rcot_pkg::CfgW-1:0]  cap_r;
  logic [rcot_pkg::CfgW-1:0]  cap_nxt;
  logic                       accept;

  assign in_stall   = stg_vld_r && !push_ready;
  assign accept     = in_valid && !in_stall;
  assign push_valid = stg_vld_r;
  assign push_data  = stg_r;

  always_comb begin
    cap_nxt     = cfg_we ? cfg_wdata : cap_r;
    stg_vld_nxt = stg_vld_r;
    stg_nxt     = stg_r;
    if (stg_vld_r && push_ready) begin
      stg_vld_nxt = 1'b0;
    end
    if (accept) begin
      stg_vld_nxt  = 1'b1;
      stg_nxt.op   = rcot_pkg::op_t'(in_kind);
      stg_nxt.key  = in_key_tag;
      stg_nxt.data = in_data_word;
    end
  end

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = rcot_pkg::CntW'(1);
    end else if (32'(cap_r) > 32'(rcot_pkg::MaxEntries)) begin
      eff_cap = rcot_pkg::CntW'(rcot_pkg::MaxEntries);
    end else begin
      eff_cap = rcot_pkg::CntW'(cap_r);
    end
  end

  always_ff @(posedge clk) begin
    stg_r <= stg_nxt;
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      cap_r     <= rcot_pkg::CapReset;
    end else begin
      stg_vld_r <= stg_vld_nxt;
      cap_r     <= cap_nxt;
    end
  end

endmodule

// ===== design/rcot_queue.sv =====
// Short request queue between the front and back stages.
`timescale 1ns / 1ps
module rcot_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  rcot_pkg::req_t push_data,
  output logic           pop_valid,
  input  logic           pop,
  output rcot_pkg::req_t pop_data
);

  rcot_pkg::req_t                slot_r [rcot_pkg::QueueDepth];
  logic [rcot_pkg::QPtrW-1:0]    wr_ptr_r;
  logic [rcot_pkg::QPtrW-1:0]    wr_ptr_nxt;
  logic [rcot_pkg::QPtrW-1:0]    rd_ptr_r;
  logic [rcot_pkg::QPtrW-1:0]    rd_ptr_nxt;
  logic [rcot_pkg::QCntW-1:0]    cnt_r;
  logic [rcot_pkg::QCntW-1:0]    cnt_nxt;
  logic                          do_push;
  logic                          do_pop;

  assign push_ready = cnt_r != rcot_pkg::QCntW'(rcot_pkg::QueueDepth);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == rcot_pkg::QueueDepth - 1) ? '0
                                                              : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == rcot_pkg::QueueDepth - 1) ? '0
                                                              : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== design/rcot_back.sv =====
// Back stage: ordered entry list, tag compare, list update and result register.
`timescale 1ns / 1ps
`include "recency_ordered_cache_table_defines.svh"
module rcot_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  rcot_pkg::req_t              q_data,
  input  logic [rcot_pkg::CntW-1:0]   eff_cap,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_found,
  output logic [rcot_pkg::DataW-1:0]  out_read_data,
  output logic                        out_evicted
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

  state_t                              state_r;
  state_t                              state_nxt;
  rcot_pkg::req_t                      cur_r;
  rcot_pkg::req_t                      cur_nxt;
  logic [rcot_pkg::MaxEntries-1:0]     match_r;
  logic [rcot_pkg::MaxEntries-1:0]     match_nxt;
  logic [rcot_pkg::KeyW-1:0]           keys_r [rcot_pkg::MaxEntries];
  logic [rcot_pkg::KeyW-1:0]           keys_nxt [rcot_pkg::MaxEntries];
  logic [rcot_pkg::DataW-1:0]          data_r [rcot_pkg::MaxEntries];
  logic [rcot_pkg::DataW-1:0]          data_nxt [rcot_pkg::MaxEntries];
  logic [rcot_pkg::CntW-1:0]           held_r;
  logic [rcot_pkg::CntW-1:0]           held_nxt;
  logic                                out_vld_r;
  logic                                out_vld_nxt;
  logic                                out_found_r;
  logic                                out_found_nxt;
  logic [rcot_pkg::DataW-1:0]          out_rdata_r;
  logic [rcot_pkg::DataW-1:0]          out_rdata_nxt;
  logic                                out_ev_r;
  logic                                out_ev_nxt;
  logic [rcot_pkg::MaxEntries-1:0]     match_now;
  logic                                out_free;
  logic                                hit;
  logic [rcot_pkg::IdxW-1:0]           hit_pos;
  logic                                full;
  logic                                shift_en;
  logic [rcot_pkg::IdxW-1:0]           shift_from;
  logic [rcot_pkg::IdxW-1:0]           wr_idx;

  assign out_valid     = out_vld_r;
  assign out_found     = out_found_r;
  assign out_read_data = out_rdata_r;
  assign out_evicted   = out_ev_r;
  assign out_free      = !out_vld_r || !out_stall;
  assign q_pop         = q_valid && ((state_r == ST_IDLE) || ((state_r == ST_UPD) && out_free));

  always_comb begin
    for (int i = 0; i < rcot_pkg::MaxEntries; i++) begin
      match_now[i] = (rcot_pkg::CntW'(i) < held_r) && (keys_r[i] == cur_r.key);
    end
  end

  always_comb begin
    hit_pos = '0;
    for (int i = rcot_pkg::MaxEntries - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        hit_pos = rcot_pkg::IdxW'(i);
      end
    end
  end

  assign hit        = |match_r;
  assign full       = held_r >= eff_cap;
  assign shift_en   = (cur_r.op == rcot_pkg::OP_PUT) && (hit || full);
  assign shift_from = hit ? hit_pos : '0;
  assign wr_idx     = shift_en ? rcot_pkg::IdxW'(held_r - rcot_pkg::CntW'(1))
                               : rcot_pkg::IdxW'(held_r);

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    match_nxt     = match_r;
    keys_nxt      = keys_r;
    data_nxt      = data_r;
    held_nxt      = held_r;
    out_vld_nxt   = out_vld_r;
    out_found_nxt = out_found_r;
    out_rdata_nxt = out_rdata_r;
    out_ev_nxt    = out_ev_r;
    if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          cur_nxt   = q_data;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        match_nxt = match_now;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          out_vld_nxt   = 1'b1;
          out_found_nxt = hit;
          out_rdata_nxt = '0;
          out_ev_nxt    = 1'b0;
          if (cur_r.op == rcot_pkg::OP_GET) begin
            if (hit) begin
              out_rdata_nxt = data_r[hit_pos];
            end
          end else begin
            out_ev_nxt = !hit && full;
            if (!shift_en) begin
              held_nxt = held_r + rcot_pkg::CntW'(1);
            end
            for (int i = 0; i < rcot_pkg::MaxEntries - 1; i++) begin
              if (shift_en && (rcot_pkg::IdxW'(i) >= shift_from) &&
                  (rcot_pkg::CntW'(i + 1) < held_r)) begin
                keys_nxt[i] = keys_r[i + 1];
                data_nxt[i] = data_r[i + 1];
              end
            end
            keys_nxt[wr_idx] = cur_r.key;
            data_nxt[wr_idx] = cur_r.data;
          end
          if (q_valid) begin
            cur_nxt   = q_data;
            state_nxt = ST_CMP;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    match_r     <= match_nxt;
    keys_r      <= keys_nxt;
    data_r      <= data_nxt;
    out_found_r <= out_found_nxt;
    out_rdata_r <= out_rdata_nxt;
    out_ev_r    <= out_ev_nxt;
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      held_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      held_r    <= held_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  `RCOT_ASSERT_IMPL(a_held_bound, clk, rst_n, 1'b1,
                    32'(held_r) <= rcot_pkg::MaxEntries)
  `RCOT_ASSERT_IMPL(a_evict_on_miss, clk, rst_n, out_vld_r && out_ev_r, !out_found_r)
  `RCOT_ASSERT_IMPL(a_miss_zero_data, clk, rst_n, out_vld_r && !out_found_r,
                    out_rdata_r == '0)
  `RCOT_ASSERT_NEXT(a_cmp_then_upd, clk, rst_n, state_r == ST_CMP, state_r == ST_UPD)

endmodule

// ===== design/recency_ordered_cache_table.sv =====
// Top level of the recency ordered cache table.
`timescale 1ns / 1ps
// Fully associative cache of up to 16 key/data pairs kept in order from oldest
// to newest. A put refreshes a present key to newest, appends a new key while
// fewer than the configured capacity are held, or else drops the oldest entry;
// a get returns the found flag and data without changing the order. The back
// stage handles each item in a compare state for the parallel tag compare and
// then an update state for the list shift and result write, which waits while
// the output is stalled; it takes the next item only once the last result is written. The
// capacity register may be written only while the block is idle.
module recency_ordered_cache_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_kind,
  input  logic [rcot_pkg::KeyW-1:0]   in_key_tag,
  input  logic [rcot_pkg::DataW-1:0]  in_data_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_found,
  output logic [rcot_pkg::DataW-1:0]  out_read_data,
  output logic                        out_evicted,
  input  logic                        cfg_we,
  input  logic [rcot_pkg::CfgW-1:0]   cfg_wdata
);

  logic                        push_valid;
  logic                        push_ready;
  rcot_pkg::req_t              push_data;
  logic                        q_valid;
  logic                        q_pop;
  rcot_pkg::req_t              q_data;
  logic [rcot_pkg::CntW-1:0]   eff_cap;

  rcot_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_key_tag   (in_key_tag),
    .in_data_word (in_data_word),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data),
    .eff_cap      (eff_cap)
  );

  rcot_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  rcot_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_data        (q_data),
    .eff_cap       (eff_cap),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_found     (out_found),
    .out_read_data (out_read_data),
    .out_evicted   (out_evicted)
  );

endmodule

// ===== tb/cache_table_checker.sv =====
// Checker that predicts each cache table result and compares it at the output.
`timescale 1ns / 1ps
module cache_table_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_kind,
  input  logic [rcot_pkg::KeyW-1:0]   in_key_tag,
  input  logic [rcot_pkg::DataW-1:0]  in_data_word,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        out_found,
  input  logic [rcot_pkg::DataW-1:0]  out_read_data,
  input  logic                        out_evicted,
  input  logic                        cfg_we,
  input  logic [rcot_pkg::CfgW-1:0]   cfg_wdata,
  output int                          outstanding,
  output int                          fail_count
);

  typedef struct packed {
    logic                       found;
    logic [rcot_pkg::DataW-1:0] read_data;
    logic                       evicted;
  } lookup_result_t;

  logic [rcot_pkg::KeyW-1:0]  tag_list [rcot_pkg::MaxEntries];
  logic [rcot_pkg::DataW-1:0] word_list [rcot_pkg::MaxEntries];
  int                         held = 0;
  logic [rcot_pkg::CfgW-1:0]  capacity = rcot_pkg::CapReset;
  int                         mismatches = 0;
  lookup_result_t             expected_results [$];

  function automatic lookup_result_t apply_op(rcot_pkg::op_t op,
                                              logic [rcot_pkg::KeyW-1:0] key,
                                              logic [rcot_pkg::DataW-1:0] word);
    lookup_result_t r;
    int limit;
    int pos;
    bit hit;
    r = '0;
    limit = (capacity == 0) ? 1
          : ((capacity > rcot_pkg::MaxEntries) ? rcot_pkg::MaxEntries : capacity);
    hit = 1'b0;
    pos = 0;
    for (int i = 0; i < held; i++) begin
      if (!hit && tag_list[i] == key) begin
        hit = 1'b1;
        pos = i;
      end
    end
    r.found = hit;
    if (op == rcot_pkg::OP_GET) begin
      if (hit) r.read_data = word_list[pos];
    end else if (!hit && held < limit) begin
      tag_list[held] = key;
      word_list[held] = word;
      held++;
    end else begin
      if (!hit) begin
        pos = 0;
        r.evicted = 1'b1;
      end
      for (int i = pos; i + 1 < held; i++) begin
        tag_list[i] = tag_list[i + 1];
        word_list[i] = word_list[i + 1];
      end
      tag_list[held - 1] = key;
      word_list[held - 1] = word;
    end
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [rcot_pkg::DataW-1:0] want,
                               logic [rcot_pkg::DataW-1:0] got);
    if (mismatches < 10) begin
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst_n) begin
      held = 0;
      capacity = rcot_pkg::CapReset;
      expected_results.delete();
    end else begin
      if (cfg_we) capacity = cfg_wdata;
      if (in_valid && !in_stall) begin
        expected_results.insert(expected_results.size(),
                                apply_op(rcot_pkg::op_t'(in_kind), in_key_tag, in_data_word));
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected item", '0, out_read_data);
        end else begin
          want = expected_results.pop_front();
          if (out_found !== want.found) begin
            note_mismatch("found", rcot_pkg::DataW'(want.found), rcot_pkg::DataW'(out_found));
          end
          if (out_read_data !== want.read_data) begin
            note_mismatch("read_data", want.read_data, out_read_data);
          end
          if (out_evicted !== want.evicted) begin
            note_mismatch("evicted", rcot_pkg::DataW'(want.evicted),
                          rcot_pkg::DataW'(out_evicted));
          end
        end
      end
    end
    outstanding <= expected_results.size();
    fail_count <= mismatches;
  end

endmodule

// ===== tb/tb.sv =====
// Top of the cache table testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_kind = 1'b0;
  logic [rcot_pkg::KeyW-1:0]  in_key_tag = '0;
  logic [rcot_pkg::DataW-1:0] in_data_word = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_found;
  logic [rcot_pkg::DataW-1:0] out_read_data;
  logic                       out_evicted;
  logic                       cfg_we = 1'b0;
  logic [rcot_pkg::CfgW-1:0]  cfg_wdata = '0;
  int                         outstanding;
  int                         fail_count;
  bit                         idle_on = 1'b1;
  logic [rcot_pkg::KeyW-1:0]  key_pool [24];
  int                         phase_caps [12] = '{16, 1, 4, 0, 31, 8, 3, 17, 5, 16, 2, 12};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  recency_ordered_cache_table DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_key_tag   (in_key_tag),
    .in_data_word (in_data_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_found    (out_found),
    .out_read_data(out_read_data),
    .out_evicted  (out_evicted),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  cache_table_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_key_tag   (in_key_tag),
    .in_data_word (in_data_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_found    (out_found),
    .out_read_data(out_read_data),
    .out_evicted  (out_evicted),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .outstanding  (outstanding),
    .fail_count   (fail_count)
  );

  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(0, 99) < 17);
  end

  task automatic send_item(rcot_pkg::op_t op, logic [rcot_pkg::KeyW-1:0] key,
                           logic [rcot_pkg::DataW-1:0] word);
    while (idle_on && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= op;
    in_key_tag <= key;
    in_data_word <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_capacity(logic [rcot_pkg::CfgW-1:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int count, int pool_n);
    rcot_pkg::op_t             op;
    logic [rcot_pkg::KeyW-1:0] key;
    repeat (count) begin
      op = ($urandom_range(0, 99) < 40) ? rcot_pkg::OP_GET : rcot_pkg::OP_PUT;
      key = ($urandom_range(0, 9) == 0) ? $urandom()
                                        : key_pool[$urandom_range(0, pool_n - 1)];
      send_item(op, key, $urandom());
    end
  endtask

  initial begin
    int held_limit;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty cache, both extreme keys, a refresh and a miss.
    send_item(rcot_pkg::OP_GET, '0, 32'h0000_1234);
    send_item(rcot_pkg::OP_PUT, '0, '1);
    send_item(rcot_pkg::OP_PUT, '1, '0);
    send_item(rcot_pkg::OP_GET, '0, '0);
    send_item(rcot_pkg::OP_GET, '1, '1);
    send_item(rcot_pkg::OP_PUT, '0, 32'hA5A5_5A5A);
    send_item(rcot_pkg::OP_GET, '0, '0);
    send_item(rcot_pkg::OP_GET, 32'h5555_AAAA, '0);

    // Small capacity: eviction of the oldest, then a refresh that protects a key.
    set_capacity(5'd2);
    send_item(rcot_pkg::OP_PUT, 32'h0000_0011, 32'h1111_1111);
    send_item(rcot_pkg::OP_GET, '1, '0);
    send_item(rcot_pkg::OP_PUT, 32'h0000_0022, 32'h2222_2222);
    send_item(rcot_pkg::OP_PUT, 32'h0000_0022, 32'h3333_3333);
    send_item(rcot_pkg::OP_PUT, 32'h0000_0044, 32'h4444_4444);
    send_item(rcot_pkg::OP_GET, 32'h0000_0022, '0);

    // Capacity zero acts as one, and lies below the count already held.
    set_capacity(5'd0);
    send_item(rcot_pkg::OP_PUT, 32'h0000_0055, 32'h5555_5555);
    send_item(rcot_pkg::OP_GET, 32'h0000_0044, '0);
    send_item(rcot_pkg::OP_PUT, 32'h0000_0066, 32'h6666_6666);
    send_item(rcot_pkg::OP_GET, 32'h0000_0055, '0);

    // Capacity above the table size saturates.
    set_capacity(5'd31);
    send_item(rcot_pkg::OP_PUT, 32'h0000_0077, 32'h7777_7777);
    send_item(rcot_pkg::OP_PUT, 32'h0000_0066, '1);
    send_item(rcot_pkg::OP_GET, 32'h0000_0066, '0);

    foreach (phase_caps[p]) begin
      set_capacity(phase_caps[p][rcot_pkg::CfgW-1:0]);
      held_limit = (phase_caps[p] == 0) ? 1
                 : ((phase_caps[p] > rcot_pkg::MaxEntries) ? rcot_pkg::MaxEntries
                                                           : phase_caps[p]);
      idle_on = (p != 6);
      random_phase(145, (held_limit + 4 > 24) ? 24 : held_limit + 4);
      idle_on = 1'b1;
    end

    wait_idle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
